// ===== rtl/core/seven_segment_scan_blink_core_macros.svh =====
// Assertion macros for the seven-segment scan core.
// Used by the top level; expects clk and rst_n in the scope of the use.
`ifndef SEVEN_SEGMENT_SCAN_BLINK_CORE_MACROS_SVH
`define SEVEN_SEGMENT_SCAN_BLINK_CORE_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define SSB_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define SSB_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/ssb_pkg.sv =====
// Shared types, constants and the segment font for the seven-segment scan core.
// No dependencies; every other file but the assertion macros header imports this package.
package ssb_pkg;

    localparam logic [4:0] POS_FIRST = 5'd1;
    localparam logic [4:0] POS_LAST  = 5'd22;

    localparam logic [7:0] BLINK_PERIOD_RST = 8'd200;
    localparam logic [7:0] BLINK_OFF_RST    = 8'd70;

    localparam logic [7:0] SEG_DARK    = 8'h00;
    localparam logic [7:0] SEG_LETTER_C = 8'h39;
    localparam logic [7:0] SEG_LETTER_T = 8'h78;
    localparam logic [7:0] SEG_LETTER_N = 8'h37;

    localparam logic [2:0] WEEKDAY_SUNDAY = 3'd1;

    typedef enum logic [0:0] {
        REG_BLINK_PERIOD = 1'b0,
        REG_BLINK_OFF    = 1'b1
    } ssb_reg_t;

    typedef enum logic [3:0] {
        EDIT_NONE    = 4'd0,
        EDIT_DAY     = 4'd1,
        EDIT_MONTH   = 4'd2,
        EDIT_YEAR    = 4'd3,
        EDIT_WEEKDAY = 4'd4,
        EDIT_HOUR    = 4'd5,
        EDIT_MINUTE  = 4'd6,
        EDIT_SECOND  = 4'd7
    } ssb_edit_t;

    typedef struct packed {
        logic [4:0] solar_day;
        logic [3:0] solar_month;
        logic [6:0] solar_year;
        logic [4:0] lunar_day;
        logic [3:0] lunar_month;
        logic [6:0] lunar_year;
        logic [2:0] weekday;
        logic [6:0] temperature;
        logic [4:0] hours;
        logic [5:0] minutes;
        logic [5:0] seconds;
        logic [3:0] edit_field;
    } ssb_in_t;

    typedef struct packed {
        logic [7:0] segments;
        logic [4:0] digit_index;
        logic       frame_start;
    } ssb_out_t;

    typedef struct packed {
        logic [7:0] blink_period;
        logic [7:0] blink_off_count;
    } ssb_cfg_t;

    // Word held between the counter stage and the decode stage.
    typedef struct packed {
        ssb_in_t    item;
        logic [4:0] pos;
        logic       frame;
        logic [7:0] blink;
    } ssb_scan_t;

    // Common-cathode font, bit 0 is segment a. Codes above nine are dark.
    function automatic logic [7:0] glyph(input logic [3:0] d);
        logic [7:0] seg;
        case (d)
            4'd0:    seg = 8'h3f;
            4'd1:    seg = 8'h06;
            4'd2:    seg = 8'h5b;
            4'd3:    seg = 8'h4f;
            4'd4:    seg = 8'h66;
            4'd5:    seg = 8'h6d;
            4'd6:    seg = 8'h7d;
            4'd7:    seg = 8'h07;
            4'd8:    seg = 8'h7f;
            4'd9:    seg = 8'h6f;
            default: seg = SEG_DARK;
        endcase
        return seg;
    endfunction

endpackage

// ===== rtl/core/ssb_channels.sv =====
// Valid/ready channel interfaces for input words and result words.
// Depends on ssb_pkg for the payload types.
interface ssb_in_if;
    import ssb_pkg::*;
    logic    valid;
    logic    ready;
    ssb_in_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface ssb_out_if;
    import ssb_pkg::*;
    logic     valid;
    logic     ready;
    ssb_out_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/core/ssb_apb_regs.sv =====
// APB-style register file holding the blink period and blink-off threshold.
// Depends on ssb_pkg.
module ssb_apb_regs (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             psel,
    input  logic             penable,
    input  logic             pwrite,
    input  logic [2:0]       paddr,
    input  logic [31:0]      pwdata,
    output logic [31:0]      prdata,
    output logic             pready,
    output ssb_pkg::ssb_cfg_t cfg
);
    import ssb_pkg::*;

    logic [7:0] period_reg;
    logic [7:0] off_reg;
    logic       wr_en;
    ssb_reg_t   sel;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;
    assign sel    = ssb_reg_t'(paddr[2]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            period_reg <= BLINK_PERIOD_RST;
            off_reg    <= BLINK_OFF_RST;
        end
        else if (wr_en)
        begin
            case (sel)
                REG_BLINK_PERIOD: period_reg <= pwdata[7:0];
                REG_BLINK_OFF:    off_reg    <= pwdata[7:0];
                default:          ;
            endcase
        end
    end

    always_comb
    begin
        case (sel)
            REG_BLINK_PERIOD: prdata = {24'd0, period_reg};
            REG_BLINK_OFF:    prdata = {24'd0, off_reg};
            default:          prdata = 32'd0;
        endcase
    end

    assign cfg.blink_period    = period_reg;
    assign cfg.blink_off_count = off_reg;

endmodule

// ===== rtl/core/ssb_scan_ctrl.sv =====
// Input register stage: steps the digit and blink counters on each accepted word.
// Depends on ssb_pkg and ssb_channels.
module ssb_scan_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    ssb_in_if.sink             in_ch,
    input  ssb_pkg::ssb_cfg_t  cfg,
    input  logic               stage_ready,
    output logic               stage_valid,
    output ssb_pkg::ssb_scan_t stage
);
    import ssb_pkg::*;

    logic [4:0] digit_reg;
    logic [4:0] digit_next;
    logic [7:0] blink_reg;
    logic [7:0] blink_next;
    logic [8:0] blink_inc;
    logic       wrap;
    logic       accept;
    logic       valid_reg;
    logic       valid_next;
    ssb_scan_t  stage_reg;

    assign in_ch.ready = !valid_reg || stage_ready;
    assign accept      = in_ch.valid && in_ch.ready;

    always_comb
    begin
        wrap       = (digit_reg >= POS_LAST);
        digit_next = wrap ? POS_FIRST : digit_reg + 5'd1;
        // A period at or below the incremented count sends the counter back to zero.
        blink_inc  = {1'b0, blink_reg} + 9'd1;
        blink_next = (blink_inc >= {1'b0, cfg.blink_period}) ? 8'd0 : blink_inc[7:0];
        valid_next = accept || (valid_reg && !stage_ready);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            digit_reg <= 5'd0;
            blink_reg <= 8'd0;
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
            if (accept)
            begin
                digit_reg <= digit_next;
                blink_reg <= blink_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            stage_reg.item  <= in_ch.data;
            stage_reg.pos   <= digit_next;
            stage_reg.frame <= wrap;
            stage_reg.blink <= blink_next;
        end
    end

    assign stage_valid = valid_reg;
    assign stage       = stage_reg;

endmodule

// ===== rtl/core/ssb_seg_decode.sv =====
// Result stage: picks the value for the current position, splits it into
// digits, applies blanking and blinking, and registers the segment word.
// Depends on ssb_pkg and ssb_channels.
module ssb_seg_decode (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               stage_valid,
    input  ssb_pkg::ssb_scan_t stage,
    input  ssb_pkg::ssb_cfg_t  cfg,
    output logic               stage_ready,
    ssb_out_if.source          out_ch
);
    import ssb_pkg::*;

    logic [6:0]  val;
    logic        blank_zero;
    logic        is_wday;
    logic        pos_ok;
    ssb_edit_t   grp;
    logic [14:0] prod;
    logic [3:0]  tens;
    logic [6:0]  units;
    logic [7:0]  tens_seg;
    logic [7:0]  units_seg;
    logic        dark;
    logic        sunday;
    logic [7:0]  seg;
    logic        load;
    logic        out_valid_reg;
    ssb_out_t    out_data_reg;

    always_comb
    begin
        val        = 7'd0;
        blank_zero = 1'b0;
        is_wday    = 1'b0;
        pos_ok     = 1'b1;
        grp        = EDIT_NONE;
        case (stage.pos)
            5'd1, 5'd2:
            begin
                val        = {2'd0, stage.item.solar_day};
                blank_zero = 1'b1;
                grp        = EDIT_DAY;
            end
            5'd3, 5'd4:
            begin
                val        = {3'd0, stage.item.solar_month};
                blank_zero = 1'b1;
                grp        = EDIT_MONTH;
            end
            5'd5, 5'd6:
            begin
                val = stage.item.solar_year;
                grp = EDIT_YEAR;
            end
            5'd7, 5'd8:
            begin
                val        = {2'd0, stage.item.lunar_day};
                blank_zero = 1'b1;
            end
            5'd9, 5'd10:
            begin
                val        = {3'd0, stage.item.lunar_month};
                blank_zero = 1'b1;
            end
            5'd11, 5'd12:
            begin
                val = stage.item.lunar_year;
            end
            5'd13, 5'd14:
            begin
                val     = {4'd0, stage.item.weekday};
                is_wday = 1'b1;
                grp     = EDIT_WEEKDAY;
            end
            5'd15, 5'd16:
            begin
                val        = stage.item.temperature;
                blank_zero = 1'b1;
            end
            5'd17, 5'd18:
            begin
                val = {2'd0, stage.item.hours};
                grp = EDIT_HOUR;
            end
            5'd19, 5'd20:
            begin
                val = {1'd0, stage.item.minutes};
                grp = EDIT_MINUTE;
            end
            5'd21, 5'd22:
            begin
                val = {1'd0, stage.item.seconds};
                grp = EDIT_SECOND;
            end
            default:
            begin
                pos_ok = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        // Divide by ten as multiply by 205 and shift by 11, exact below 1029.
        prod      = {8'd0, val} * 15'd205;
        tens      = prod[14:11];
        units     = val - ({3'd0, tens} * 7'd10);
        tens_seg  = (blank_zero && (val < 7'd10)) ? SEG_DARK : glyph(tens);
        units_seg = glyph(units[3:0]);
        sunday    = (stage.item.weekday == WEEKDAY_SUNDAY);
        dark      = (grp != EDIT_NONE) && (stage.item.edit_field == grp)
                    && (stage.blink <= cfg.blink_off_count);

        // Odd positions carry the tens digit of their pair.
        if (!pos_ok || dark)
            seg = SEG_DARK;
        else if (is_wday)
            seg = stage.pos[0] ? (sunday ? SEG_LETTER_C : SEG_LETTER_T)
                               : (sunday ? SEG_LETTER_N : units_seg);
        else
            seg = stage.pos[0] ? tens_seg : units_seg;
    end

    assign stage_ready = !out_valid_reg || out_ch.ready;
    assign load        = stage_valid && stage_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (stage_ready)
            out_valid_reg <= stage_valid;
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            out_data_reg.segments    <= seg;
            out_data_reg.digit_index <= stage.pos;
            out_data_reg.frame_start <= stage.frame;
        end
    end

    assign out_ch.valid = out_valid_reg;
    assign out_ch.data  = out_data_reg;

endmodule

// ===== rtl/core/seven_segment_scan_blink_core.sv =====
// Top level of the multiplexed seven-segment scan core with edit blinking.
// Depends on ssb_pkg, ssb_channels, ssb_apb_regs, ssb_scan_ctrl, ssb_seg_decode
// and the assertion macros header.
//
//   channel  | role   | word
//   ---------+--------+-----------------------------------------------
//   in_ch    | sink   | display values and edit group, one scan tick
//   out_ch   | source | segment byte, digit position, frame start
//   APB      | slave  | blink_period at 0x0, blink_off_count at 0x4
//
// From acceptance a word passes through the counter register stage, then the decode
// and result register. One word is accepted per cycle unless a stalled result backs up.
// Each stage has its own valid bit, so a stalled result holds only its own
// register and the input stays ready while the counter stage is free.
// Reset clears the counters and valid bits and restores the register defaults.
module seven_segment_scan_blink_core (
    input  logic        clk,
    input  logic        rst_n,
    ssb_in_if.sink      in_ch,
    ssb_out_if.source   out_ch,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import ssb_pkg::*;
    `include "seven_segment_scan_blink_core_macros.svh"

    ssb_cfg_t  cfg;
    ssb_scan_t stage;
    logic      stage_valid;
    logic      stage_ready;

    ssb_apb_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    ssb_scan_ctrl u_scan (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_ch       (in_ch),
        .cfg         (cfg),
        .stage_ready (stage_ready),
        .stage_valid (stage_valid),
        .stage       (stage)
    );

    ssb_seg_decode u_decode (
        .clk         (clk),
        .rst_n       (rst_n),
        .stage_valid (stage_valid),
        .stage       (stage),
        .cfg         (cfg),
        .stage_ready (stage_ready),
        .out_ch      (out_ch)
    );

    `SSB_ASSERT_NOW(a_index_range, out_ch.valid, (out_ch.data.digit_index >= POS_FIRST) && (out_ch.data.digit_index <= POS_LAST), "digit index out of range")
    `SSB_ASSERT_NOW(a_frame_first, out_ch.valid && out_ch.data.frame_start, out_ch.data.digit_index == POS_FIRST, "frame start away from first digit")
    `SSB_ASSERT_NOW(a_backpressure, !in_ch.ready, out_ch.valid && stage_valid, "input stalled with an empty stage")
    `SSB_ASSERT_NEXT(a_accept_fills, in_ch.valid && in_ch.ready, stage_valid, "accepted word not held in counter stage")

endmodule
